### rtl/shuffled_minimal_standard_rng_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shuffled minimal-standard generator
// Implication checks, same-cycle and next-cycle, reported with $error.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_MINIMAL_STANDARD_RNG_CORE_ASSERT_SVH
`define SHUFFLED_MINIMAL_STANDARD_RNG_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SRNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srng: same-cycle check failed");
`define SRNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srng: next-cycle check failed");
`else
`define SRNG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRNG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/srng_pkg.sv
// ----------------------------------------------------------------------------
// srng_pkg
// Shared widths, generator constants, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srng_pkg;

    localparam int WORD_W     = 31;
    localparam int MULT_W     = 15;
    localparam int PROD_W     = WORD_W + MULT_W;
    localparam int WARM_EXTRA = 8;

    localparam logic [MULT_W-1:0] MS_MULT = 15'd16807;
    localparam logic [WORD_W-1:0] MS_MOD  = 31'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MS_ONE  = 31'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WMUL,
        S_WRED,
        S_DMUL,
        S_RED,
        S_OUT
    } t_state;

    // Datapath commands, at most a few active in one cycle
    typedef struct packed {
        logic load_start;     // load state from seed, arm warm-up counter
        logic mul;            // register state * multiplier
        logic warm_red;       // reduce, write table during warm-up
        logic slot_from_last; // recompute slot from last output
        logic draw_red;       // reduce, swap table slot
        logic finish;         // load output, update last output and slot
    } t_dp_cmd;

    typedef struct packed {
        logic last_zero;      // generator not yet initialized
        logic cnt_zero;       // final warm-up step
    } t_dp_status;

endpackage

### rtl/srng_req_if.sv
// ----------------------------------------------------------------------------
// srng_req_if
// Request channel: draw or reseed-and-draw, with a seed.
// ----------------------------------------------------------------------------
interface srng_req_if
    import srng_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [WORD_W-1:0] seed;

    modport source (output valid, output kind, output seed, input ready);
    modport sink   (input valid, input kind, input seed, output ready);
endinterface

### rtl/srng_rsp_if.sv
// ----------------------------------------------------------------------------
// srng_rsp_if
// Response channel: one shuffled 31-bit deviate per request.
// ----------------------------------------------------------------------------
interface srng_rsp_if
    import srng_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### rtl/srng_ctrl.sv
// ----------------------------------------------------------------------------
// srng_ctrl
// Sequencer for warm-up and draws; owns the response valid flag.
// ----------------------------------------------------------------------------
module srng_ctrl
    import srng_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_kind,
    output logic       o_req_ready,
    input  logic       i_rsp_ready,
    output logic       o_rsp_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   n_rsp_valid;
    logic   rsp_free;
    logic   accept;

    assign rsp_free    = !r_rsp_valid || i_rsp_ready;
    assign accept      = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_rsp_valid;

    // Take a request when idle, or while the result load frees the sequencer
    assign o_req_ready = i_rst_n
                       && ((r_state == S_IDLE) || ((r_state == S_OUT) && rsp_free));

    // Hold state and output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_WMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WRED;
            end
            S_WRED: begin
                o_cmd.warm_red = 1'b1;
                n_state        = i_status.cnt_zero ? S_DMUL : S_WMUL;
            end
            S_DMUL: begin
                o_cmd.mul            = 1'b1;
                o_cmd.slot_from_last = 1'b1;
                n_state              = S_RED;
            end
            S_RED: begin
                o_cmd.draw_red = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (rsp_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Start a new item: warm up first on reseed or before any seed
        if (accept) begin
            if (i_req_kind || i_status.last_zero) begin
                o_cmd.load_start = 1'b1;
                n_state          = S_WMUL;
            end else begin
                o_cmd.mul = 1'b1;
                n_state   = S_RED;
            end
        end
    end

    // Set on result load, drop on transfer
    always_comb begin
        if (o_cmd.finish) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

endmodule

### rtl/srng_dp.sv
// ----------------------------------------------------------------------------
// srng_dp
// Generator state, multiplier, Mersenne reduction, shuffle table and
// output register.
// ----------------------------------------------------------------------------
module srng_dp
    import srng_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_kind,
    input  logic [WORD_W-1:0] i_req_seed,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic [WORD_W-1:0] o_rsp_value
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + WARM_EXTRA);
    localparam logic [31:0] SLOT_DIV = 32'(1 + (2147483646 / TABLE_ENTRIES));
    localparam logic [CW-1:0] CNT_INIT = CW'(TABLE_ENTRIES + WARM_EXTRA - 1);
    localparam logic [CW-1:0] CNT_FILL = CW'(TABLE_ENTRIES);

    logic [WORD_W-1:0] r_state;
    logic [PROD_W-1:0] r_prod;
    logic [CW-1:0]     r_cnt;
    logic [WORD_W-1:0] r_last;
    logic [AW-1:0]     r_slot;
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_value;
    logic [WORD_W-1:0] r_table [TABLE_ENTRIES];

    logic [WORD_W-1:0] start;
    logic [WORD_W:0]   fold_sum;
    logic [WORD_W-1:0] fold;
    logic              tbl_we;
    logic [AW-1:0]     tbl_wa;
    logic [WORD_W-1:0] slot_src;
    logic [AW-1:0]     slot_new;

    // Slot of a value: highest k with value >= k * SLOT_DIV, capped at the top
    function automatic logic [AW-1:0] slot_of(input logic [WORD_W-1:0] v);
        logic [AW-1:0] s;
        s = '0;
        for (int k = 1; k < TABLE_ENTRIES; k++) begin
            if ({1'b0, v} >= 32'(k) * SLOT_DIV) begin
                s = AW'(k);
            end
        end
        return s;
    endfunction

    // Zero seed and the modulus itself map to one
    assign start = (i_req_kind && (i_req_seed != '0) && (i_req_seed != MS_MOD))
                   ? i_req_seed : MS_ONE;

    // Fold the product: high part plus low part mod 2^31-1
    assign fold_sum = {1'b0, r_prod[WORD_W-1:0]}
                    + {{(WORD_W + 1 - MULT_W){1'b0}}, r_prod[PROD_W-1:WORD_W]};
    assign fold     = (fold_sum >= {1'b0, MS_MOD}) ? WORD_W'(fold_sum - {1'b0, MS_MOD})
                                                  : fold_sum[WORD_W-1:0];

    assign tbl_we   = (i_cmd.warm_red && (r_cnt < CNT_FILL)) || i_cmd.draw_red;
    assign tbl_wa   = i_cmd.draw_red ? r_slot : r_cnt[AW-1:0];
    assign slot_src = i_cmd.finish ? r_rd : r_last;
    assign slot_new = slot_of(slot_src);

    assign o_status.last_zero = (r_last == '0);
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_rsp_value        = r_value;

    // Advance generator state, warm-up counter and last output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_ONE;
            r_last  <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.load_start) begin
                r_state <= start;
                r_cnt   <= CNT_INIT;
            end else if (i_cmd.warm_red || i_cmd.draw_red) begin
                r_state <= fold;
            end
            if (i_cmd.warm_red && !o_status.cnt_zero) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.warm_red && o_status.cnt_zero) begin
                r_last <= fold;
            end else if (i_cmd.finish) begin
                r_last <= r_rd;
            end
        end
    end

    // Multiply, slot and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_state * MS_MULT;
        end
        if (i_cmd.slot_from_last || i_cmd.finish) begin
            r_slot <= slot_new;
        end
        if (i_cmd.finish) begin
            r_value <= r_rd;
        end
    end

    // Shuffle table: read old word and write new state in the same cycle
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_wa] <= fold;
        end
        if (i_cmd.draw_red) begin
            r_rd <= r_table[r_slot];
        end
    end

endmodule

### rtl/shuffled_minimal_standard_rng_core.sv
// ----------------------------------------------------------------------------
// shuffled_minimal_standard_rng_core
// Park-Miller generator (x16807 mod 2^31-1) behind a Bays-Durham shuffle.
//
//   port    dir   modport  payload
//   i_req   in    sink     kind (1b: 0 draw, 1 reseed+draw), seed (31b)
//   o_rsp   out   source   value (31b, 1 .. 2^31-2)
//
// A draw multiplies, then reduces and swaps a table slot, then loads the result;
// a draw taken during a result load starts its multiply there. Each generator
// step is a multiply then a reduce. A reseed, or the first draw after reset,
// first adds a warm-up that fills the table and sets the last output.
// Reset is synchronous; the table holds no defined data until a warm-up.
// A finished result waits in the output register; one more request is taken
// meanwhile and then stalls before its result load until the register frees.
// ----------------------------------------------------------------------------
`include "shuffled_minimal_standard_rng_core_assert.svh"

module shuffled_minimal_standard_rng_core
    import srng_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srng_req_if.sink    i_req,
    srng_rsp_if.source  o_rsp
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer
    srng_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_kind  (i_req.kind),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Generator and shuffle table
    srng_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_kind  (i_req.kind),
        .i_req_seed  (i_req.seed),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_rsp_value (o_rsp.value)
    );

    // Results are never the fixed point or the modulus
    `SRNG_ASSERT_IMP(a_value_nonzero, i_clk, i_rst_n, o_rsp.valid, o_rsp.value != '0)
    `SRNG_ASSERT_IMP(a_value_below_mod, i_clk, i_rst_n, o_rsp.valid, o_rsp.value != MS_MOD)
    // Busy right after a transfer in
    `SRNG_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    // A table swap only happens after a warm-up
    `SRNG_ASSERT_IMP(a_draw_initialized, i_clk, i_rst_n, cmd.draw_red, !status.last_zero)

endmodule
